>>> hw/rtl/cdll_pkg.sv
// Shared definitions for the circular doubly linked list manager.
// Command and status codes, payload types and default sizes.
// No dependencies.
package cdll_pkg;

   localparam int CDLL_CAPACITY = 16;
   localparam int MAX_RESULTS   = 16;

   typedef logic [2:0]        cmd_type;
   typedef logic [1:0]        status_type;
   typedef logic signed [31:0] value_type;

   localparam cmd_type CMD_PUSH_FRONT   = 3'd0;
   localparam cmd_type CMD_PUSH_BACK    = 3'd1;
   localparam cmd_type CMD_INSERT_AFTER = 3'd2;
   localparam cmd_type CMD_POP_FRONT    = 3'd3;
   localparam cmd_type CMD_POP_BACK     = 3'd4;
   localparam cmd_type CMD_DELETE_MATCH = 3'd5;
   localparam cmd_type CMD_READ_OUT     = 3'd6;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_EMPTY     = 2'd1;
   localparam status_type ST_NOT_FOUND = 2'd2;
   localparam status_type ST_FULL      = 2'd3;

endpackage

>>> hw/rtl/circular_doubly_linked_list_manager_unit.sv
// Circular doubly linked list manager: values, next and prev links in three slot memories
// read at one shared address, registered. Full or empty answers go via FIN; push goes via ALONE
// (empty list) or PUSH_RD, LINK1, LINK2; pop front via POP_RD, UNLINK; pop back via POPB_RD,
// POP_RD, UNLINK; insert-after and delete walk in SEARCH, then LINK1, LINK2 or UNLINK, or answer
// not found; read out emits one element per cycle while taken. Requests are taken in IDLE only,
// after the last result is registered. Synchronous reset clears state, map, head, count, rsp_valid.
module circular_doubly_linked_list_manager_unit
   import cdll_pkg::*;
#(
   parameter int CAPACITY = CDLL_CAPACITY
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  cmd_type    req_cmd,
   input  value_type  req_new_value,
   input  value_type  req_match_value,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output status_type rsp_status,
   output value_type  rsp_element_value,
   output logic       rsp_last_result
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int RW = $clog2(MAX_RESULTS + 1);
   localparam int SW = (CW > RW) ? CW : RW;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_FIN     = 4'd1;
   localparam logic [3:0] S_ALONE   = 4'd2;
   localparam logic [3:0] S_PUSH_RD = 4'd3;
   localparam logic [3:0] S_LINK1   = 4'd4;
   localparam logic [3:0] S_LINK2   = 4'd5;
   localparam logic [3:0] S_SEARCH  = 4'd6;
   localparam logic [3:0] S_POPB_RD = 4'd7;
   localparam logic [3:0] S_POP_RD  = 4'd8;
   localparam logic [3:0] S_UNLINK  = 4'd9;
   localparam logic [3:0] S_WALK    = 4'd10;

   // slot memories
   value_type         val_mem  [CAPACITY];
   logic [AW-1:0]     next_mem [CAPACITY];
   logic [AW-1:0]     prev_mem [CAPACITY];
   value_type         val_rd_ff;
   logic [AW-1:0]     next_rd_ff;
   logic [AW-1:0]     prev_rd_ff;

   logic              val_we, next_we, prev_we;
   logic [AW-1:0]     val_wa, next_wa, prev_wa;
   value_type         val_wd;
   logic [AW-1:0]     next_wd, prev_wd;

   logic [3:0]        state_ff, state_in;
   logic [CAPACITY-1:0] inuse_ff, inuse_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [AW-1:0]     node_ff, node_in;
   logic [AW-1:0]     prv_ff, prv_in;
   logic [AW-1:0]     nxt_ff, nxt_in;
   logic [SW-1:0]     step_ff, step_in;
   cmd_type           cmd_ff, cmd_in;
   value_type         nv_ff, nv_in;
   value_type         mv_ff, mv_in;
   status_type        fin_st_ff, fin_st_in;
   value_type         fin_val_ff, fin_val_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   value_type         rsp_value_ff, rsp_value_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [AW-1:0]     free_slot;
   logic              list_full, list_empty, accept, out_free, emit;
   logic              walk_last, search_end;
   logic [SW-1:0]     step_next;
   status_type        emit_st;
   value_type         emit_val;
   logic              emit_last;

   // lowest free slot
   always_comb begin
      free_slot = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!inuse_ff[i]) free_slot = AW'(i);
      end
   end

   assign list_full  = &inuse_ff;
   assign list_empty = (count_ff == '0);
   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign step_next  = step_ff + SW'(1);
   assign walk_last  = (step_next == SW'(count_ff)) || (step_next == SW'(MAX_RESULTS));
   assign search_end = (step_next == SW'(count_ff));

   always_comb begin
      state_in   = state_ff;
      inuse_in   = inuse_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      addr_in    = addr_ff;
      node_in    = node_ff;
      prv_in     = prv_ff;
      nxt_in     = nxt_ff;
      step_in    = step_ff;
      cmd_in     = cmd_ff;
      nv_in      = nv_ff;
      mv_in      = mv_ff;
      fin_st_in  = fin_st_ff;
      fin_val_in = fin_val_ff;
      val_we     = 1'b0;
      next_we    = 1'b0;
      prev_we    = 1'b0;
      val_wa     = node_ff;
      next_wa    = node_ff;
      prev_wa    = node_ff;
      val_wd     = nv_ff;
      next_wd    = nxt_ff;
      prev_wd    = prv_ff;
      emit       = 1'b0;
      emit_st    = fin_st_ff;
      emit_val   = fin_val_ff;
      emit_last  = 1'b1;

      case (state_ff)
         S_IDLE: begin
            addr_in = head_ff;
            if (accept) begin
               cmd_in     = req_cmd;
               nv_in      = req_new_value;
               mv_in      = req_match_value;
               node_in    = free_slot;
               step_in    = '0;
               fin_val_in = '0;
               fin_st_in  = ST_OK;
               case (req_cmd)
                  CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                     if (list_full) begin
                        fin_st_in = ST_FULL;
                        state_in  = S_FIN;
                     end else if (list_empty) begin
                        state_in = S_ALONE;
                     end else begin
                        state_in = S_PUSH_RD;
                     end
                  end
                  CMD_INSERT_AFTER: begin
                     if (list_full) begin
                        fin_st_in = ST_FULL;
                        state_in  = S_FIN;
                     end else if (list_empty) begin
                        fin_st_in = ST_EMPTY;
                        state_in  = S_FIN;
                     end else begin
                        state_in = S_SEARCH;
                     end
                  end
                  CMD_POP_FRONT, CMD_POP_BACK, CMD_DELETE_MATCH, CMD_READ_OUT: begin
                     if (list_empty) begin
                        fin_st_in = ST_EMPTY;
                        state_in  = S_FIN;
                     end else if (req_cmd == CMD_POP_FRONT) begin
                        state_in = S_POP_RD;
                     end else if (req_cmd == CMD_POP_BACK) begin
                        state_in = S_POPB_RD;
                     end else if (req_cmd == CMD_DELETE_MATCH) begin
                        state_in = S_SEARCH;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  default: state_in = S_IDLE;  // unknown command: no result
               endcase
            end
         end

         S_ALONE: begin
            val_we   = 1'b1;
            next_we  = 1'b1;
            prev_we  = 1'b1;
            next_wd  = node_ff;
            prev_wd  = node_ff;
            inuse_in[node_ff] = 1'b1;
            head_in  = node_ff;
            count_in = CW'(1);
            state_in = S_FIN;
         end

         S_PUSH_RD: begin
            // new node goes between the tail and the head
            prv_in   = prev_rd_ff;
            nxt_in   = head_ff;
            state_in = S_LINK1;
         end

         S_LINK1: begin
            val_we   = 1'b1;
            next_we  = 1'b1;
            prev_we  = 1'b1;
            state_in = S_LINK2;
         end

         S_LINK2: begin
            next_we  = 1'b1;
            next_wa  = prv_ff;
            next_wd  = node_ff;
            prev_we  = 1'b1;
            prev_wa  = nxt_ff;
            prev_wd  = node_ff;
            inuse_in[node_ff] = 1'b1;
            count_in = count_ff + CW'(1);
            if (cmd_ff == CMD_PUSH_FRONT) head_in = node_ff;
            state_in = S_FIN;
         end

         S_SEARCH: begin
            if (val_rd_ff == mv_ff) begin
               nxt_in = next_rd_ff;
               if (cmd_ff == CMD_INSERT_AFTER) begin
                  prv_in   = addr_ff;
                  state_in = S_LINK1;
               end else begin
                  node_in  = addr_ff;
                  prv_in   = prev_rd_ff;
                  state_in = S_UNLINK;
               end
            end else if (search_end) begin
               fin_st_in = ST_NOT_FOUND;
               state_in  = S_FIN;
            end else begin
               addr_in = next_rd_ff;
               step_in = step_next;
            end
         end

         S_POPB_RD: begin
            addr_in  = prev_rd_ff;
            state_in = S_POP_RD;
         end

         S_POP_RD: begin
            node_in    = addr_ff;
            prv_in     = prev_rd_ff;
            nxt_in     = next_rd_ff;
            fin_val_in = val_rd_ff;
            state_in   = S_UNLINK;
         end

         S_UNLINK: begin
            inuse_in[node_ff] = 1'b0;
            if (count_ff == CW'(1)) begin
               head_in  = '0;
               count_in = '0;
            end else begin
               next_we  = 1'b1;
               next_wa  = prv_ff;
               next_wd  = nxt_ff;
               prev_we  = 1'b1;
               prev_wa  = nxt_ff;
               prev_wd  = prv_ff;
               count_in = count_ff - CW'(1);
               if (head_ff == node_ff) head_in = nxt_ff;
            end
            state_in = S_FIN;
         end

         S_WALK: begin
            // read data for addr_ff is held while the output is stalled
            if (out_free) begin
               emit      = 1'b1;
               emit_st   = ST_OK;
               emit_val  = val_rd_ff;
               emit_last = walk_last;
               if (walk_last) begin
                  state_in = S_IDLE;
               end else begin
                  addr_in = next_rd_ff;
                  step_in = step_next;
               end
            end
         end

         S_FIN: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = emit_st;
         rsp_value_in  = emit_val;
         rsp_last_in   = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (val_we) val_mem[val_wa] <= val_wd;
      val_rd_ff <= val_mem[addr_in];
   end

   always_ff @(posedge clock) begin
      if (next_we) next_mem[next_wa] <= next_wd;
      next_rd_ff <= next_mem[addr_in];
   end

   always_ff @(posedge clock) begin
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      prev_rd_ff <= prev_mem[addr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         inuse_ff     <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         inuse_ff     <= inuse_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      node_ff       <= node_in;
      prv_ff        <= prv_in;
      nxt_ff        <= nxt_in;
      step_ff       <= step_in;
      cmd_ff        <= cmd_in;
      nv_ff         <= nv_in;
      mv_ff         <= mv_in;
      fin_st_ff     <= fin_st_in;
      fin_val_ff    <= fin_val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_element_value = rsp_value_ff;
   assign rsp_last_result   = rsp_last_ff;

   a_count_matches_map: assert property (@(posedge clock) disable iff (reset)
      CW'($countones(inuse_ff)) == count_ff)
      else $error("element count differs from occupancy map");

   a_empty_head_zero: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == '0))
      else $error("empty list with nonzero head");

   a_head_in_use: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> inuse_ff[head_ff])
      else $error("head slot not occupied");

   a_search_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> (step_ff < SW'(count_ff)))
      else $error("search walked past the list length");

   a_emit_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before taken");

endmodule
